>>> src/srb_pkg.sv
// Shared constants for the sequence reassembly buffer.
// Command and status codes, parameter defaults. No dependencies.
package srb_pkg;

  localparam int unsigned SRB_ENTRIES     = 16;
  localparam int unsigned SRB_MAX_PAYLOAD = 256;
  localparam int unsigned SRB_SEQ_BITS    = 16;
  localparam logic [4:0]  SRB_MAX_RESET   = 5'd16;

  localparam logic [2:0] CMD_ADD  = 3'd0;
  localparam logic [2:0] CMD_RUN  = 3'd1;
  localparam logic [2:0] CMD_ALL  = 3'd2;
  localparam logic [2:0] CMD_CLR  = 3'd3;
  localparam logic [2:0] CMD_READ = 3'd4;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_DUP    = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_NODATA = 3'd3;
  localparam logic [2:0] ST_BUSY   = 3'd4;
  localparam logic [2:0] ST_LONG   = 3'd5;

endpackage

>>> src/sequence_reassembly_buffer.sv
// Sequence reassembly buffer, top level.
// Depends on srb_pkg and srb_payload_ram.
//
// Usage:
// s_axis carries one command per item: tuser = {data_valid, command},
// tdata = {data, seq}, tlast = last byte of a payload being added.
// m_axis returns one result per command 0..4: tuser = {byte_valid, status},
// tdata packs byte_out, run_length, frames_taken, complete, gap, next_seq,
// tlast = final byte of the current extraction. Commands 5..7 give no item.
// cfg_valid_i/cfg_data_i write max_entries; the user must do so only while
// the block is idle, which the block does not enforce. A sequencer walks the
// slot table one entry per cycle; each command 0..4 ends with a status pass
// and an output step. A read reads the RAM, a commit checks duplicates,
// extract-all marks then searches, extract-run rescans per frame then
// searches; a read ending a payload adds a search, as does each empty payload
// skipped. s_axis_tready is high only while the sequencer is idle. A result
// waits in the output register while the receiver stalls; the next command
// is still accepted and holds at its last step until the register frees.
// Reset empties the table and sets max_entries to 16; no clearing pass.
module sequence_reassembly_buffer
  import srb_pkg::*;
#(
  parameter int unsigned ENTRIES     = SRB_ENTRIES,
  parameter int unsigned MAX_PAYLOAD = SRB_MAX_PAYLOAD,
  parameter int unsigned SEQ_BITS    = SRB_SEQ_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // seq[15:0], data[23:16]
  input  logic [3:0]  s_axis_tuser,   // command[2:0], data_valid[3]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // byte_out[7:0], run_length[20:8], frames_taken[25:21], complete[26],
  // gap[27], next_seq[43:28], zero[47:44]
  output logic [47:0] m_axis_tdata,
  output logic [3:0]  m_axis_tuser,   // status[2:0], byte_valid[3]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);

  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam int unsigned LEN_W  = $clog2(MAX_PAYLOAD + 2);
  localparam int unsigned RUN_W  = $clog2(ENTRIES * MAX_PAYLOAD + 1);
  localparam int unsigned DEPTH  = ENTRIES * MAX_PAYLOAD;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);
  localparam logic [SEQ_BITS-1:0] SEQ_TOP = {SEQ_BITS{1'b1}};
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PAYLOAD);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_DUP     = 12'b000000000010,
    S_COMMIT  = 12'b000000000100,
    S_RUN     = 12'b000000001000,
    S_RUN_END = 12'b000000010000,
    S_ALL     = 12'b000000100000,
    S_ALL_END = 12'b000001000000,
    S_ADV     = 12'b000010000000,
    S_ADV_END = 12'b000100000000,
    S_RDW     = 12'b001000000000,
    S_STAT    = 12'b010000000000,
    S_FIN     = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SEQ_BITS-1:0] lo_q, lo_d, hi_q, hi_d, s_q, s_d, cseq_q, cseq_d;
  logic                cpl_q, cpl_d, dup_q, dup_d;
  logic                best_v_q, best_v_d;
  logic [IDX_W-1:0]    best_q, best_d;
  logic [SEQ_BITS-1:0] best_seq_q, best_seq_d;
  logic [CNT_W-1:0]    frames_q, frames_d;
  logic [RUN_W-1:0]    run_q, run_d;
  logic [2:0]          status_q, status_d, cmd_q, cmd_d;
  logic [7:0]          byte_q, byte_d;
  logic                bvalid_q, bvalid_d, lbyte_q, lbyte_d;
  logic [ENTRIES-1:0]  valid_q, valid_d, marks_q, marks_d;
  logic [SEQ_BITS-1:0] next_seq_q, next_seq_d;
  logic                started_q, started_d;
  logic                stg_act_q, stg_act_d, stg_noslot_q, stg_noslot_d;
  logic [IDX_W-1:0]    stg_slot_q, stg_slot_d;
  logic [LEN_W-1:0]    stg_cnt_q, stg_cnt_d;
  logic                drn_act_q, drn_act_d;
  logic [IDX_W-1:0]    drn_slot_q, drn_slot_d;
  logic [LEN_W-1:0]    drn_off_q, drn_off_d;
  logic [4:0]          max_q;
  logic                out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [47:0]         out_data_q, out_data_d;
  logic [3:0]          out_user_q, out_user_d;

  logic [SEQ_BITS-1:0] slot_seq_q [ENTRIES];
  logic [LEN_W-1:0]    slot_len_q [ENTRIES];
  logic                slot_we;

  logic [2:0]          cmd_in;
  logic                dv_in, in_hs;
  logic [31:0]         seq_ext;
  logic [SEQ_BITS-1:0] seq_in, cur_seq;
  logic [LEN_W-1:0]    cur_len;
  logic                cur_v;
  logic [ENTRIES-1:0]  free_vec;
  logic [IDX_W-1:0]    free_idx;
  logic                free_any;
  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [7:0]          ram_rdata;
  logic [LEN_W-1:0]    off_n;
  logic                gap;
  logic [SEQ_BITS:0]   span;
  logic [31:0]         ns_ext, run_ext, frames_ext;

  assign cmd_in  = s_axis_tuser[2:0];
  assign dv_in   = s_axis_tuser[3];
  assign seq_ext = {16'd0, s_axis_tdata[15:0]};
  assign seq_in  = seq_ext[SEQ_BITS-1:0];
  assign in_hs   = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;

  assign cur_seq = slot_seq_q[idx_q];
  assign cur_len = slot_len_q[idx_q];
  assign cur_v   = valid_q[idx_q];
  assign off_n   = drn_off_q + LEN_W'(1);

  assign free_vec = ~valid_q & ~marks_q;
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_idx = IDX_W'(i);
        free_any = 1'b1;
      end
    end
  end

  assign span = {1'b0, hi_q} - {1'b0, lo_q} + (SEQ_BITS + 1)'(1);
  assign gap  = (cnt_q != '0) && (span != (SEQ_BITS + 1)'(cnt_q));
  assign ns_ext     = 32'(next_seq_q);
  assign run_ext    = 32'(run_q);
  assign frames_ext = 32'(frames_q);

  assign ram_raddr = ADDR_W'(32'(drn_slot_q) * MAX_PAYLOAD + 32'(drn_off_q));
  assign ram_re    = in_hs && (cmd_in == CMD_READ) && drn_act_q;
  assign slot_we   = (state_q == S_COMMIT) && !dup_q && !stg_noslot_q &&
                     (32'(cnt_q) < 32'(max_q)) && (stg_cnt_q <= LEN_MAX);

  always_comb begin
    logic             act;
    logic             noslot;
    logic [IDX_W-1:0] slot;
    logic [LEN_W-1:0] count;
    act    = stg_act_q;
    noslot = stg_noslot_q;
    slot   = stg_slot_q;
    count  = stg_cnt_q;
    ram_we = 1'b0;
    ram_waddr = '0;

    state_d = state_q;   idx_d = idx_q;       cnt_d = cnt_q;
    lo_d = lo_q;         hi_d = hi_q;         s_d = s_q;
    cseq_d = cseq_q;     cpl_d = cpl_q;       dup_d = dup_q;
    best_v_d = best_v_q; best_d = best_q;     best_seq_d = best_seq_q;
    frames_d = frames_q; run_d = run_q;       status_d = status_q;
    cmd_d = cmd_q;       byte_d = byte_q;     bvalid_d = bvalid_q;
    lbyte_d = lbyte_q;   valid_d = valid_q;   marks_d = marks_q;
    next_seq_d = next_seq_q;   started_d = started_q;
    stg_act_d = stg_act_q;     stg_noslot_d = stg_noslot_q;
    stg_slot_d = stg_slot_q;   stg_cnt_d = stg_cnt_q;
    drn_act_d = drn_act_q;     drn_slot_d = drn_slot_q;
    drn_off_d = drn_off_q;
    out_valid_d = out_valid_q; out_data_d = out_data_q;
    out_user_d = out_user_q;   out_last_d = out_last_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_hs) begin
          cmd_d = cmd_in;   cseq_d = seq_in;   status_d = ST_OK;
          byte_d = '0;      bvalid_d = 1'b0;   lbyte_d = 1'b0;
          run_d = '0;       frames_d = '0;     idx_d = '0;
          cnt_d = '0;       lo_d = '0;         hi_d = '0;
          cpl_d = 1'b0;     dup_d = 1'b0;      best_v_d = 1'b0;
          unique case (cmd_in)
            CMD_ADD: begin
              if (!act && (dv_in || s_axis_tlast)) begin
                act = 1'b1; count = '0; slot = free_idx; noslot = !free_any;
              end
              if (dv_in) begin
                if (count < LEN_MAX) begin
                  ram_we = !noslot;
                  ram_waddr = ADDR_W'(32'(slot) * MAX_PAYLOAD + 32'(count));
                  count = count + LEN_W'(1);
                end else begin
                  count = LEN_MAX + LEN_W'(1);
                end
              end
              stg_act_d = act; stg_noslot_d = noslot;
              stg_slot_d = slot; stg_cnt_d = count;
              state_d = s_axis_tlast ? S_DUP : S_STAT;
            end
            CMD_RUN, CMD_ALL: begin
              if (drn_act_q) begin
                status_d = ST_BUSY;
                state_d = S_STAT;
              end else begin
                s_d = next_seq_q;
                state_d = (cmd_in == CMD_RUN) ? S_RUN : S_ALL;
              end
            end
            CMD_CLR: begin
              valid_d = '0; marks_d = '0; next_seq_d = '0; started_d = 1'b0;
              stg_act_d = 1'b0; stg_noslot_d = 1'b0; stg_slot_d = '0;
              stg_cnt_d = '0; drn_act_d = 1'b0; drn_slot_d = '0; drn_off_d = '0;
              state_d = S_STAT;
            end
            CMD_READ: begin
              if (drn_act_q) begin
                state_d = S_RDW;
              end else begin
                status_d = ST_NODATA;
                state_d = S_STAT;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_DUP: begin
        if (cur_v && cur_seq == cseq_q) dup_d = 1'b1;
        if (cur_v) cnt_d = cnt_q + CNT_W'(1);
        if (idx_q == IDX_LAST) state_d = S_COMMIT;
        else idx_d = idx_q + IDX_W'(1);
      end
      S_COMMIT: begin
        if (dup_q) begin
          status_d = ST_DUP;
        end else if (32'(cnt_q) >= 32'(max_q) || stg_noslot_q) begin
          status_d = ST_FULL;
        end else if (stg_cnt_q > LEN_MAX) begin
          status_d = ST_LONG;
        end else begin
          valid_d[stg_slot_q] = 1'b1;
          if (!started_q || cseq_q < next_seq_q) begin
            next_seq_d = cseq_q;
            started_d = 1'b1;
          end
        end
        stg_act_d = 1'b0; stg_cnt_d = '0;
        idx_d = '0; cnt_d = '0;
        state_d = S_STAT;
      end
      S_RUN: begin
        if (cur_v && cur_seq == s_q) begin
          marks_d[idx_q] = 1'b1;
          valid_d[idx_q] = 1'b0;
          frames_d = frames_q + CNT_W'(1);
          run_d = run_q + RUN_W'(cur_len);
          idx_d = '0;
          if (s_q == SEQ_TOP) begin
            state_d = S_RUN_END;
          end else begin
            s_d = s_q + SEQ_BITS'(1);
            if (32'(frames_q) + 32'd1 == ENTRIES) state_d = S_RUN_END;
          end
        end else if (idx_q == IDX_LAST) begin
          state_d = S_RUN_END;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_RUN_END: begin
        idx_d = '0;
        if (frames_q == '0) begin
          status_d = ST_NODATA;
          state_d = S_STAT;
        end else begin
          next_seq_d = s_q;
          best_v_d = 1'b0;
          state_d = S_ADV;
        end
      end
      S_ALL: begin
        if (cur_v) begin
          if (cur_seq > hi_q) hi_d = cur_seq;
          marks_d[idx_q] = 1'b1;
          valid_d[idx_q] = 1'b0;
          frames_d = frames_q + CNT_W'(1);
          run_d = run_q + RUN_W'(cur_len);
        end
        if (idx_q == IDX_LAST) state_d = S_ALL_END;
        else idx_d = idx_q + IDX_W'(1);
      end
      S_ALL_END: begin
        idx_d = '0; hi_d = '0;
        if (frames_q == '0) begin
          status_d = ST_NODATA;
          state_d = S_STAT;
        end else begin
          next_seq_d = (hi_q == SEQ_TOP) ? SEQ_TOP : hi_q + SEQ_BITS'(1);
          best_v_d = 1'b0;
          state_d = S_ADV;
        end
      end
      S_ADV: begin
        if (marks_q[idx_q] && (!best_v_q || cur_seq < best_seq_q)) begin
          best_v_d = 1'b1; best_d = idx_q; best_seq_d = cur_seq;
        end
        if (idx_q == IDX_LAST) state_d = S_ADV_END;
        else idx_d = idx_q + IDX_W'(1);
      end
      S_ADV_END: begin
        idx_d = '0;
        if (!best_v_q) begin
          drn_act_d = 1'b0;
          if (cmd_q == CMD_READ) lbyte_d = 1'b1;
          state_d = S_STAT;
        end else if (slot_len_q[best_q] == '0) begin
          marks_d[best_q] = 1'b0;
          best_v_d = 1'b0;
          state_d = S_ADV;
        end else begin
          drn_slot_d = best_q; drn_off_d = '0; drn_act_d = 1'b1;
          state_d = S_STAT;
        end
      end
      S_RDW: begin
        byte_d = ram_rdata; bvalid_d = 1'b1;
        drn_off_d = off_n;
        idx_d = '0;
        if (off_n >= slot_len_q[drn_slot_q]) begin
          marks_d[drn_slot_q] = 1'b0;
          best_v_d = 1'b0;
          state_d = S_ADV;
        end else begin
          state_d = S_STAT;
        end
      end
      S_STAT: begin
        if (cur_v) begin
          if (cnt_q == '0 || cur_seq < lo_q) lo_d = cur_seq;
          if (cnt_q == '0 || cur_seq > hi_q) hi_d = cur_seq;
          if (cur_seq == next_seq_q) cpl_d = 1'b1;
          cnt_d = cnt_q + CNT_W'(1);
        end
        if (idx_q == IDX_LAST) state_d = S_FIN;
        else idx_d = idx_q + IDX_W'(1);
      end
      S_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_user_d = {bvalid_q, status_q};
          out_last_d = lbyte_q;
          out_data_d = {4'd0, ns_ext[15:0], gap, cpl_q, frames_ext[4:0],
                        run_ext[12:0], byte_q};
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;    idx_q <= '0;       cnt_q <= '0;
      cpl_q <= 1'b0;        dup_q <= 1'b0;     best_v_q <= 1'b0;
      valid_q <= '0;        marks_q <= '0;     next_seq_q <= '0;
      started_q <= 1'b0;    stg_act_q <= 1'b0; stg_noslot_q <= 1'b0;
      stg_slot_q <= '0;     stg_cnt_q <= '0;   drn_act_q <= 1'b0;
      drn_slot_q <= '0;     drn_off_q <= '0;   max_q <= SRB_MAX_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;   idx_q <= idx_d;    cnt_q <= cnt_d;
      cpl_q <= cpl_d;       dup_q <= dup_d;    best_v_q <= best_v_d;
      valid_q <= valid_d;   marks_q <= marks_d; next_seq_q <= next_seq_d;
      started_q <= started_d; stg_act_q <= stg_act_d; stg_noslot_q <= stg_noslot_d;
      stg_slot_q <= stg_slot_d; stg_cnt_q <= stg_cnt_d; drn_act_q <= drn_act_d;
      drn_slot_q <= drn_slot_d; drn_off_q <= drn_off_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) max_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;         hi_q <= hi_d;         s_q <= s_d;
    cseq_q <= cseq_d;     best_q <= best_d;     best_seq_q <= best_seq_d;
    frames_q <= frames_d; run_q <= run_d;       status_q <= status_d;
    cmd_q <= cmd_d;       byte_q <= byte_d;     bvalid_q <= bvalid_d;
    lbyte_q <= lbyte_d;   out_data_q <= out_data_d;
    out_user_q <= out_user_d; out_last_q <= out_last_d;
    if (slot_we) begin
      slot_seq_q[stg_slot_q] <= cseq_q;
      slot_len_q[stg_slot_q] <= stg_cnt_q;
    end
  end

  srb_payload_ram #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(s_axis_tdata[23:16]),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

>>> src/srb_payload_ram.sv
// Payload byte store of the reassembly buffer.
// One write port, one registered read port. Does not use srb_pkg.
module srb_payload_ram #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
